// File: sv/byte_substring_finder_unit_macros.svh
// Assertion macros shared by the substring finder.
`ifndef BYTE_SUBSTRING_FINDER_UNIT_MACROS_SVH
`define BYTE_SUBSTRING_FINDER_UNIT_MACROS_SVH

`ifndef NO_ASSERTIONS

// The condition must always hold outside reset.
`define BSF_ASSERT_ALWAYS(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("substring finder check failed");

// The consequent must hold in the same cycle as the antecedent.
`define BSF_ASSERT_IMPLY(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("substring finder check failed");

`else

`define BSF_ASSERT_ALWAYS(label, clk, rst_n, prop)
`define BSF_ASSERT_IMPLY(label, clk, rst_n, cond, prop)

`endif

`endif

// File: sv/bsf_pkg.sv
package bsf_pkg;

    // Window depth and haystack limit.
    localparam int MAX_NEEDLE   = 32;
    localparam int MAX_HAYSTACK = 65536;

    // Fixed field widths.
    localparam int BYTE_W       = 8;
    localparam int LEN_W        = 6;
    localparam int WORD_W       = 64;
    localparam int CFG_WORDS    = 4;
    localparam int NEEDLE_BYTES = CFG_WORDS * WORD_W / BYTE_W;
    localparam int NB_IDX_W     = $clog2(NEEDLE_BYTES);
    localparam int CFG_IDX_W    = 3;
    localparam int POS_W        = 16;
    localparam int CNT_W        = $clog2(MAX_HAYSTACK + 1);

    // Depth of the queue between front and back.
    localparam int QUEUE_DEPTH  = 2;
    localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_NEEDLE_LENGTH = 3'd0,
        REG_NEEDLE_WORD_0 = 3'd1,
        REG_NEEDLE_WORD_1 = 3'd2,
        REG_NEEDLE_WORD_2 = 3'd3,
        REG_NEEDLE_WORD_3 = 3'd4
    } bsf_reg_t;

    // One classified byte on its way to the back end.
    typedef struct packed {
        logic             hit;
        logic [POS_W-1:0] pos;
        logic             last;
    } bsf_item_t;

    // Queue status seen by both sides.
    typedef struct packed {
        logic full;
        logic empty;
    } bsf_qstat_t;

endpackage

// File: sv/bsf_front.sv
module bsf_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [bsf_pkg::BYTE_W-1:0]    haystack_byte,
    input  logic                          last_byte,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [bsf_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [bsf_pkg::WORD_W-1:0]    cfg_data,
    input  bsf_pkg::bsf_qstat_t           qstat,
    output logic                          push,
    output bsf_pkg::bsf_item_t            item
);
    import bsf_pkg::*;

    logic [LEN_W-1:0]                        len_reg;
    logic [NEEDLE_BYTES-1:0][BYTE_W-1:0]     needle_reg;
    logic [CNT_W-1:0]                        seen_reg;
    logic [CNT_W-1:0]                        seen_next;
    logic [CNT_W-1:0]                        seen_inc;
    logic [BYTE_W-1:0]                       window_reg [MAX_NEEDLE];
    logic [BYTE_W-1:0]                       window_next [MAX_NEEDLE];
    logic [MAX_NEEDLE-1:0]                   byte_ok;
    logic                                    take;
    logic                                    len_ok;
    logic                                    enough;

    // The configuration port never holds off a write.
    assign cfg_ready = 1'b1;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg    <= '0;
            needle_reg <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_NEEDLE_LENGTH: len_reg <= cfg_data[LEN_W-1:0];
                REG_NEEDLE_WORD_0: needle_reg[0*8 +: 8] <= cfg_data;
                REG_NEEDLE_WORD_1: needle_reg[1*8 +: 8] <= cfg_data;
                REG_NEEDLE_WORD_2: needle_reg[2*8 +: 8] <= cfg_data;
                REG_NEEDLE_WORD_3: needle_reg[3*8 +: 8] <= cfg_data;
                default:           ;
            endcase
        end
    end

    // A byte is taken when the queue has room for its outcome.
    assign in_stall = qstat.full;
    assign push     = in_valid && !in_stall;

    // Bytes enter the window only until the count saturates.
    assign take     = seen_reg < CNT_W'(MAX_HAYSTACK);
    assign seen_inc = seen_reg + CNT_W'(1);
    assign len_ok   = (len_reg != '0) && (int'(len_reg) <= MAX_NEEDLE);
    assign enough   = seen_inc >= CNT_W'(len_reg);

    // Window after the shift, compared against the reversed needle.
    always_comb
    begin
        logic [LEN_W-1:0] rel;
        for (int i = 0; i < MAX_NEEDLE; i++)
        begin
            window_next[i] = (i == 0) ? haystack_byte : window_reg[(i == 0) ? 0 : i - 1];
            rel = len_reg - LEN_W'(i) - LEN_W'(1);
            if (LEN_W'(i) >= len_reg)
                byte_ok[i] = 1'b1;
            else if (int'(rel) >= NEEDLE_BYTES)
                byte_ok[i] = (window_next[i] == '0);
            else
                byte_ok[i] = (window_next[i] == needle_reg[rel[NB_IDX_W-1:0]]);
        end
    end

    // Classified outcome of this byte.
    assign item.hit  = take && len_ok && enough && (&byte_ok);
    assign item.pos  = POS_W'(seen_inc - CNT_W'(len_reg));
    assign item.last = last_byte;

    // Byte count, cleared at the end of each haystack.
    always_comb
    begin
        seen_next = seen_reg;
        if (push)
        begin
            if (last_byte)
                seen_next = '0;
            else if (take)
                seen_next = seen_inc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            seen_reg <= '0;
        else
            seen_reg <= seen_next;
    end

    // The window itself; the count keeps stale bytes out of any match.
    always_ff @(posedge clk)
    begin
        if (push && take)
        begin
            for (int i = 0; i < MAX_NEEDLE; i++)
                window_reg[i] <= window_next[i];
        end
    end

endmodule

// File: sv/bsf_queue.sv
module bsf_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  bsf_pkg::bsf_item_t  item_in,
    input  logic                pop,
    output bsf_pkg::bsf_item_t  item_out,
    output bsf_pkg::bsf_qstat_t qstat
);
    import bsf_pkg::*;

    bsf_item_t          entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg;
    logic [QPTR_W-1:0]  wr_ptr_next;
    logic [QPTR_W-1:0]  rd_ptr_reg;
    logic [QPTR_W-1:0]  rd_ptr_next;
    logic [QCNT_W-1:0]  count_reg;
    logic [QCNT_W-1:0]  count_next;

    assign qstat.full  = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign qstat.empty = (count_reg == '0);
    assign item_out    = entry_reg[rd_ptr_reg];

    // Pointer and occupancy update; a push and a pop may share a cycle.
    always_comb
    begin
        wr_ptr_next = push ? QPTR_W'(wr_ptr_reg + QPTR_W'(1)) : wr_ptr_reg;
        rd_ptr_next = pop  ? QPTR_W'(rd_ptr_reg + QPTR_W'(1)) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
            count_next = count_reg + QCNT_W'(1);
        else if (pop && !push)
            count_next = count_reg - QCNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= item_in;
    end

endmodule

// File: sv/bsf_back.sv
module bsf_back (
    input  logic                      clk,
    input  logic                      rst_n,
    input  bsf_pkg::bsf_item_t        item,
    input  bsf_pkg::bsf_qstat_t       qstat,
    output logic                      pop,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic                      found,
    output logic [bsf_pkg::POS_W-1:0] position
);
    import bsf_pkg::*;

    logic             reported_reg;
    logic             reported_next;
    logic             valid_reg;
    logic             valid_next;
    logic             found_reg;
    logic [POS_W-1:0] pos_reg;
    logic             can_load;
    logic             emit_found;
    logic             emit_miss;

    // The output register is free when empty or being drained by a transfer.
    assign can_load   = !valid_reg || !out_stall;
    assign pop        = !qstat.empty && can_load;
    assign emit_found = item.hit && !reported_reg;
    assign emit_miss  = item.last && !reported_reg && !item.hit;

    // Match bookkeeping for the current haystack and output valid.
    always_comb
    begin
        reported_next = reported_reg;
        valid_next    = valid_reg;
        if (pop)
        begin
            if (item.last)
                reported_next = 1'b0;
            else if (emit_found)
                reported_next = 1'b1;
        end
        if (can_load)
            valid_next = pop && (emit_found || emit_miss);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reported_reg <= 1'b0;
            valid_reg    <= 1'b0;
        end
        else
        begin
            reported_reg <= reported_next;
            valid_reg    <= valid_next;
        end
    end

    // Result payload; a not-found result carries a zero position.
    always_ff @(posedge clk)
    begin
        if (pop && (emit_found || emit_miss))
        begin
            found_reg <= emit_found;
            pos_reg   <= emit_found ? item.pos : '0;
        end
    end

    assign out_valid = valid_reg;
    assign found     = found_reg;
    assign position  = pos_reg;

endmodule

// File: sv/byte_substring_finder_unit.sv
// Result path: a byte is held in a queue entry, then its result in the output register.
// Throughput: one haystack byte per cycle when not stalled; the 32-byte window compare
// against the needle is done in the front stage in the cycle the byte is taken.
// Reset (rst_n, asynchronous, active low) clears the needle registers, the byte count,
// the match flag, the queue and the output valid.
`include "byte_substring_finder_unit_macros.svh"

module byte_substring_finder_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [bsf_pkg::BYTE_W-1:0]    haystack_byte,
    input  logic                          last_byte,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic                          found,
    output logic [bsf_pkg::POS_W-1:0]     position,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [bsf_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [bsf_pkg::WORD_W-1:0]    cfg_data
);
    import bsf_pkg::*;

    logic       push;
    logic       pop;
    bsf_item_t  front_item;
    bsf_item_t  queue_item;
    bsf_qstat_t qstat;

    // Front end: configuration, window and classification.
    bsf_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .haystack_byte (haystack_byte),
        .last_byte     (last_byte),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .qstat         (qstat),
        .push          (push),
        .item          (front_item)
    );

    // Short queue between the two halves.
    bsf_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .item_in  (front_item),
        .pop      (pop),
        .item_out (queue_item),
        .qstat    (qstat)
    );

    // Back end: first-match tracking and the result register.
    bsf_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (queue_item),
        .qstat     (qstat),
        .pop       (pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .found     (found),
        .position  (position)
    );

    // Consistency checks.
    `BSF_ASSERT_IMPLY(a_no_overflow, clk, rst_n, push, !qstat.full)
    `BSF_ASSERT_IMPLY(a_no_underflow, clk, rst_n, pop, !qstat.empty)
    `BSF_ASSERT_ALWAYS(a_qstat_sane, clk, rst_n, !(qstat.full && qstat.empty))
    `BSF_ASSERT_IMPLY(a_miss_zero_pos, clk, rst_n, out_valid && !found, position == '0)

endmodule
